// ===== design/ptog_pkg.sv =====
package ptog_pkg;

    // Item modes carried on the input tuser
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE = 3'd2;
    localparam logic [2:0] REG_GRID_ROWS = 3'd3;
    localparam logic [2:0] REG_GRID_COLS = 3'd4;
    localparam logic [2:0] REG_MARGIN_EN = 3'd5;

    // Cell update constants
    localparam logic [6:0] HIT_LIMIT   = 7'd90;
    localparam logic [6:0] HIT_GAIN    = 7'd10;
    localparam logic [6:0] CELL_FULL   = 7'd100;
    localparam logic [6:0] MARGIN_GAIN = 7'd5;

    // Memory read address select
    localparam logic [1:0] ADDR_RI  = 2'd0;
    localparam logic [1:0] ADDR_HIT = 2'd1;
    localparam logic [1:0] ADDR_NB  = 2'd2;

    // Neighbor order
    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_RIGHT = 2'd3;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [9:0]         cell_size;
        logic [8:0]         grid_rows;
        logic [7:0]         grid_cols;
        logic               margin_en;
    } t_cfg;

    typedef struct packed {
        logic       load_item;
        logic       div_step;
        logic       calc;
        logic       idx;
        logic       res_load;
        logic [1:0] addr_sel;
        logic [1:0] nb_sel;
        logic       hit_wr;
        logic       nb_wr;
        logic       clr_start;
        logic       clr_wr;
        logic       out_push;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       div_last;
        logic       inb;
        logic       hit_ok;
        logic       nb_ok;
        logic       nb_need;
        logic       clr_last;
        logic       out_free;
        logic       margin_en;
    } t_sts;

endpackage

// ===== design/point_to_occupancy_grid_unit.sv =====
// Occupancy grid binning unit.
// Items arrive on the s_axis channel: tuser selects clear (0), add point (1),
// read cell (2), none (3); tdata carries x_mm, y_mm and read_index. Every item
// yields one result on m_axis: tdata holds cell_value and point_used.
// Registers (origin, cell size, grid shape, margin enable) are to be written over
// the APB port only while the unit is idle; the block itself does not enforce it.
// Work per item, from acceptance to the result register:
//   point: the bit-serial coordinate divider, index math, a read-modify-write
//   of the hit cell and, when that cell was updated and the margin is on,
//   checks and read-modify-writes of the four neighbors; a point off the grid
//   skips the cell updates;
//   read: divider bound, then the cell read; clear: one cell written per
//   cycle through the single write port.
// One item is in flight at a time; the next item is taken once the previous
// result sits in the output register.
// After reset the unit sweeps all MAX_ROWS*MAX_COLS cells (32768 at the defaults)
// of the cell memory to zero with s_axis_tready low; configuration writes are
// taken during the sweep.
// If m_axis_tready stays low the result holds in the output register and the
// unit stops before pushing the following result.
module point_to_occupancy_grid_unit
    import ptog_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // x_mm[15:0], y_mm[31:16], read_index[46:32], pad
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // cell_value[6:0], point_used[7]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic [2:0] reg_idx;
    logic [6:0] cell_value;
    logic       point_used;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x  <= 16'sd0;
            r_cfg.origin_y  <= -16'sd7000;
            r_cfg.cell_size <= 10'd100;
            r_cfg.grid_rows <= 9'd140;
            r_cfg.grid_cols <= 8'd70;
            r_cfg.margin_en <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ORIGIN_X:  r_cfg.origin_x  <= pwdata[15:0];
                REG_ORIGIN_Y:  r_cfg.origin_y  <= pwdata[15:0];
                REG_CELL_SIZE: r_cfg.cell_size <= pwdata[9:0];
                REG_GRID_ROWS: r_cfg.grid_rows <= pwdata[8:0];
                REG_GRID_COLS: r_cfg.grid_cols <= pwdata[7:0];
                REG_MARGIN_EN: r_cfg.margin_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X:  prdata = {16'd0, r_cfg.origin_x};
            REG_ORIGIN_Y:  prdata = {16'd0, r_cfg.origin_y};
            REG_CELL_SIZE: prdata = {22'd0, r_cfg.cell_size};
            REG_GRID_ROWS: prdata = {23'd0, r_cfg.grid_rows};
            REG_GRID_COLS: prdata = {24'd0, r_cfg.grid_cols};
            REG_MARGIN_EN: prdata = {31'd0, r_cfg.margin_en};
            default:       prdata = '0;
        endcase
    end

    ptog_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ptog_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (s_axis_tuser),
        .i_x_mm       (s_axis_tdata[15:0]),
        .i_y_mm       (s_axis_tdata[31:16]),
        .i_read_index (s_axis_tdata[46:32]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_cell_value (cell_value),
        .o_point_used (point_used)
    );

    assign m_axis_tdata = {point_used, cell_value};

endmodule

// ===== design/ptog_dpath.sv =====
module ptog_dpath
    import ptog_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_x_mm,
    input  logic [15:0] i_y_mm,
    input  logic [14:0] i_read_index,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [6:0]  o_cell_value,
    output logic        o_point_used
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Effective grid shape and divisor
    logic [8:0] rows_used;
    logic [7:0] cols_used;
    logic [9:0] cs;

    always_comb begin
        rows_used = (32'(i_cfg.grid_rows) > MAX_ROWS) ? 9'(MAX_ROWS) : i_cfg.grid_rows;
        cols_used = (32'(i_cfg.grid_cols) > MAX_COLS) ? 8'(MAX_COLS) : i_cfg.grid_cols;
        cs        = (i_cfg.cell_size == 10'd0) ? 10'd1 : i_cfg.cell_size;
    end

    // Item registers
    logic [1:0]  r_mode;
    logic [14:0] r_ri;
    logic [15:0] r_ax, r_ay;
    logic [9:0]  r_rx, r_ry;
    logic        r_negx, r_negy;
    logic [3:0]  r_div_cnt;

    logic signed [16:0] dx, dy;
    logic [15:0]        mx, my;

    // Select dividends: point minus origin, or robot position (zero minus origin)
    always_comb begin
        if (i_mode == MODE_READ) begin
            dx = -17'(i_cfg.origin_x);
            dy = -17'(i_cfg.origin_y);
        end else begin
            dx = 17'($signed(i_x_mm)) - 17'(i_cfg.origin_x);
            dy = 17'($signed(i_y_mm)) - 17'(i_cfg.origin_y);
        end
        mx = dx[16] ? 16'(-dx) : dx[15:0];
        my = dy[16] ? 16'(-dy) : dy[15:0];
    end

    // One restoring step per cycle on both coordinates
    logic [10:0] tx, ty;

    always_comb begin
        tx = {r_rx, r_ax[15]};
        ty = {r_ry, r_ay[15]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load_item) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_ri   <= i_read_index;
            r_ax   <= mx;
            r_ay   <= my;
            r_rx   <= '0;
            r_ry   <= '0;
            r_negx <= dx[16];
            r_negy <= dy[16];
        end else if (i_cmd.div_step) begin
            if (tx >= {1'b0, cs}) begin
                r_rx <= 10'(tx - {1'b0, cs});
                r_ax <= {r_ax[14:0], 1'b1};
            end else begin
                r_rx <= tx[9:0];
                r_ax <= {r_ax[14:0], 1'b0};
            end
            if (ty >= {1'b0, cs}) begin
                r_ry <= 10'(ty - {1'b0, cs});
                r_ay <= {r_ay[14:0], 1'b1};
            end else begin
                r_ry <= ty[9:0];
                r_ay <= {r_ay[14:0], 1'b0};
            end
        end
    end

    // Signed quotients, truncated toward zero
    logic signed [16:0] qc, qr;

    always_comb begin
        qc = r_negx ? -$signed({1'b0, r_ax}) : $signed({1'b0, r_ax});
        qr = r_negy ? -$signed({1'b0, r_ay}) : $signed({1'b0, r_ay});
    end

    // Row times columns, cell count and bounds
    logic signed [25:0] r_prod;
    logic [16:0]        r_cells;
    logic               r_inb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_prod  <= qr * $signed({1'b0, cols_used});
            r_cells <= 17'(rows_used * cols_used);
            r_inb   <= !(r_negx && r_ax != 16'd0) && !(r_negy && r_ay != 16'd0)
                       && (r_ax < {8'd0, cols_used}) && (r_ay < {7'd0, rows_used});
        end
    end

    // Flat index, robot mask match and read range
    logic signed [26:0] sum;
    logic [AW-1:0]      r_idx;
    logic [8:0]         r_row;
    logic [7:0]         r_col;
    logic               r_mask_hit;
    logic               r_ri_ok;

    always_comb begin
        sum = {r_prod[25], r_prod} + {{10{qc[16]}}, qc};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx) begin
            r_idx      <= AW'(sum[25:0]);
            r_row      <= r_ay[8:0];
            r_col      <= r_ax[7:0];
            r_mask_hit <= (sum + 27'sd1) == $signed({12'd0, r_ri});
            r_ri_ok    <= {2'b0, r_ri} < r_cells;
        end
    end

    // Neighbor address and bounds
    logic [AW-1:0] nb_addr;
    logic          nb_ok;

    always_comb begin
        unique case (i_cmd.nb_sel)
            NB_UP: begin
                nb_addr = r_idx - AW'(cols_used);
                nb_ok   = r_row != 9'd0;
            end
            NB_DOWN: begin
                nb_addr = r_idx + AW'(cols_used);
                nb_ok   = ({1'b0, r_row} + 10'd1) < {1'b0, rows_used};
            end
            NB_LEFT: begin
                nb_addr = r_idx - AW'(1);
                nb_ok   = r_col != 8'd0;
            end
            default: begin
                nb_addr = r_idx + AW'(1);
                nb_ok   = ({1'b0, r_col} + 9'd1) < {1'b0, cols_used};
            end
        endcase
    end

    // Clear sweep counter
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Cell memory
    logic [6:0]    mem [DEPTH];
    logic [6:0]    r_rdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [6:0]    wr_data;
    logic          wr_en;
    logic [7:0]    nb_sum;

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_HIT: rd_addr = r_idx;
            ADDR_NB:  rd_addr = nb_addr;
            default:  rd_addr = AW'(r_ri);
        endcase
        nb_sum = {1'b0, r_rdata} + {1'b0, MARGIN_GAIN};
        wr_en  = i_cmd.clr_wr || i_cmd.hit_wr || i_cmd.nb_wr;
        priority if (i_cmd.clr_wr) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.hit_wr) begin
            wr_addr = r_idx;
            wr_data = r_rdata + HIT_GAIN;
        end else begin
            wr_addr = nb_addr;
            wr_data = (nb_sum > {1'b0, CELL_FULL}) ? CELL_FULL : nb_sum[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Result and output register
    logic [6:0] r_val;
    logic       r_used;
    logic       r_out_valid;
    logic [6:0] r_out_val;
    logic       r_out_used;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_val  <= '0;
            r_used <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_val  <= (r_mode == MODE_READ && r_ri_ok && !r_mask_hit) ? r_rdata : 7'd0;
            r_used <= (r_mode == MODE_POINT) && r_inb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            r_out_val  <= r_val;
            r_out_used <= r_used;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_val;
    assign o_point_used = r_out_used;

    // Status to the controller
    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.div_last  = r_div_cnt == 4'd15;
        o_sts.inb       = r_inb;
        o_sts.hit_ok    = r_rdata <= HIT_LIMIT;
        o_sts.nb_ok     = nb_ok;
        o_sts.nb_need   = r_rdata < CELL_FULL;
        o_sts.clr_last  = r_clr_addr == AW'(DEPTH - 1);
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.margin_en = i_cfg.margin_en;
    end

    // Checks
    a_wr_one_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.hit_wr, i_cmd.nb_wr}))
        else $error("more than one cell write source");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_wr |-> r_rdata <= HIT_LIMIT)
        else $error("hit update on a cell above limit");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_push |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while waiting");

endmodule

// ===== design/ptog_ctrl.sv =====
module ptog_ctrl
    import ptog_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic [1:0] i_mode,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_CALC = 4'd3;
    localparam logic [3:0] S_IDX  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_HRD  = 4'd6;
    localparam logic [3:0] S_HWR  = 4'd7;
    localparam logic [3:0] S_NRD  = 4'd8;
    localparam logic [3:0] S_NWR  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_nb_k, n_nb_k;
    logic       r_clr_item, n_clr_item;
    logic       accept;

    assign o_ready = r_state == S_IDLE;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        n_nb_k     = r_nb_k;
        n_clr_item = r_clr_item;
        o_cmd      = '0;
        o_cmd.addr_sel = ADDR_RI;
        o_cmd.nb_sel   = r_nb_k;
        unique case (r_state)
            // Sweep the store with zeros
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_item ? S_OUT : S_IDLE;
                end
            end
            // Take an item and dispatch by mode
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_mode)
                        MODE_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_clr_item      = 1'b1;
                            n_state         = S_CLR;
                        end
                        MODE_POINT, MODE_READ: n_state = S_DIV;
                        default:               n_state = S_OUT;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_IDX;
            end
            S_IDX: begin
                o_cmd.idx = 1'b1;
                if (i_sts.mode == MODE_READ) begin
                    n_state = S_RD;
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state = i_sts.inb ? S_HRD : S_OUT;
                end
            end
            // Read data for a read item is valid here
            S_RD: begin
                o_cmd.res_load = 1'b1;
                n_state        = S_OUT;
            end
            S_HRD: begin
                o_cmd.addr_sel = ADDR_HIT;
                n_state        = S_HWR;
            end
            S_HWR: begin
                o_cmd.addr_sel = ADDR_HIT;
                n_nb_k         = NB_UP;
                if (i_sts.hit_ok) begin
                    o_cmd.hit_wr = 1'b1;
                    n_state      = i_sts.margin_en ? S_NRD : S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            // Skip neighbors that fall off the grid
            S_NRD: begin
                o_cmd.addr_sel = ADDR_NB;
                if (i_sts.nb_ok) begin
                    n_state = S_NWR;
                end else if (r_nb_k == NB_RIGHT) begin
                    n_state = S_OUT;
                end else begin
                    n_nb_k = r_nb_k + 2'd1;
                end
            end
            S_NWR: begin
                o_cmd.addr_sel = ADDR_NB;
                o_cmd.nb_wr    = i_sts.nb_need;
                if (r_nb_k == NB_RIGHT) begin
                    n_state = S_OUT;
                end else begin
                    n_nb_k  = r_nb_k + 2'd1;
                    n_state = S_NRD;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_push = 1'b1;
                    n_clr_item     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_nb_k     <= NB_UP;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nb_k     <= n_nb_k;
            r_clr_item <= n_clr_item;
        end
    end

    // Checks
    a_clr_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> o_cmd.clr_wr && !o_ready)
        else $error("clear sweep stalled or open to input");

    a_push_after_clr_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && i_sts.clr_last && !r_clr_item) |=> r_state == S_IDLE)
        else $error("reset sweep produced a result");

    a_nb_needs_margin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.nb_wr |-> i_sts.nb_need && i_sts.margin_en)
        else $error("neighbor written without margin");

endmodule

// ===== tb/tb_point_to_occupancy_grid_unit.sv =====
module tb_point_to_occupancy_grid_unit;
    import ptog_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROWS = 256;
    localparam int NUM_COLS = 128;
    localparam int NUM_CELLS = NUM_ROWS * NUM_COLS;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] x_mm;
        logic [15:0] y_mm;
        logic [14:0] read_index;
    } t_item;

    typedef struct {
        logic [6:0] cell_value;
        logic       point_used;
    } t_cell_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    point_to_occupancy_grid_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // x_mm[15:0], y_mm[31:16], read_index[46:32], pad
        .s_axis_tuser  (s_user),   // mode[1:0]
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // cell_value[6:0], point_used[7]
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the block's registers and cell memory
    logic signed [15:0] grid_org_x = 16'sd0;
    logic signed [15:0] grid_org_y = -16'sd7000;
    logic [9:0]  grid_cell_mm = 10'd100;
    logic [8:0]  grid_nrows = 9'd140;
    logic [7:0]  grid_ncols = 8'd70;
    logic        grid_margin = 1'b1;
    logic [6:0]  occupancy [0:NUM_CELLS-1];

    t_item        pending_items[$];
    t_cell_result expected_cells[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           errors = 0;
    longint       cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int rows_in_use();
        return grid_nrows > NUM_ROWS ? NUM_ROWS : int'(grid_nrows);
    endfunction

    function automatic int cols_in_use();
        return grid_ncols > NUM_COLS ? NUM_COLS : int'(grid_ncols);
    endfunction

    function automatic int cell_mm();
        return grid_cell_mm == 0 ? 1 : int'(grid_cell_mm);
    endfunction

    // Coordinate to cell number, truncating toward zero
    function automatic int coord_to_cell(int coord, int origin);
        return (coord - origin) / cell_mm();
    endfunction

    task automatic bump_neighbor(int idx);
        int v;
        if (occupancy[idx] < CELL_FULL) begin
            v = occupancy[idx] + MARGIN_GAIN;
            occupancy[idx] = v > CELL_FULL ? CELL_FULL : 7'(v);
        end
    endtask

    // Update the shadow grid with one item and compute the answer it gets
    task automatic bin_item(input t_item it, output t_cell_result res);
        int rows, cols, c, r, idx, rc, rr;
        longint mask;
        rows = rows_in_use();
        cols = cols_in_use();
        res.cell_value = '0;
        res.point_used = 1'b0;
        case (it.mode)
            MODE_CLEAR: begin
                for (int i = 0; i < NUM_CELLS; i++) occupancy[i] = '0;
            end
            MODE_POINT: begin
                c = coord_to_cell(int'($signed(it.x_mm)), int'(grid_org_x));
                r = coord_to_cell(int'($signed(it.y_mm)), int'(grid_org_y));
                if (r >= 0 && c >= 0 && r < rows && c < cols) begin
                    idx = r * cols + c;
                    res.point_used = 1'b1;
                    if (occupancy[idx] <= HIT_LIMIT) begin
                        occupancy[idx] = occupancy[idx] + HIT_GAIN;
                        if (grid_margin) begin
                            if (r >= 1) bump_neighbor(idx - cols);
                            if (r + 1 < rows) bump_neighbor(idx + cols);
                            if (c >= 1) bump_neighbor(idx - 1);
                            if (c + 1 < cols) bump_neighbor(idx + 1);
                        end
                    end
                end
            end
            MODE_READ: begin
                if (int'(it.read_index) < rows * cols) begin
                    rc = coord_to_cell(0, int'(grid_org_x));
                    rr = coord_to_cell(0, int'(grid_org_y));
                    mask = longint'(rr) * cols + rc + 1;
                    if (mask != longint'(it.read_index))
                        res.cell_value = occupancy[it.read_index];
                end
            end
            default: ;
        endcase
    endtask

    // Driver: present queued items, idle at random, predict on each transfer
    always @(posedge i_clk) begin
        t_item        it;
        t_cell_result res;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                it.mode = s_user;
                it.x_mm = s_data[15:0];
                it.y_mm = s_data[31:16];
                it.read_index = s_data[46:32];
                bin_item(it, res);
                expected_cells.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_user <= it.mode;
                    s_data <= {1'b0, it.read_index, it.y_mm, it.x_mm};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result transfer
    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    want = expected_cells.pop_front();
                    if (m_data[6:0] !== want.cell_value) begin
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $time, want.cell_value, m_data[6:0]);
                        errors++;
                    end
                    if (m_data[7] !== want.point_used) begin
                        $display("%0t: point_used expected %0d actual %0d",
                                 $time, want.point_used, m_data[7]);
                        errors++;
                    end
                end
            end
            m_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_point_to_occupancy_grid_unit: done, errors");
            $finish;
        end
    end

    // Register write through the configuration port, mirrored in the shadow
    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_ORIGIN_X:  grid_org_x = value[15:0];
            REG_ORIGIN_Y:  grid_org_y = value[15:0];
            REG_CELL_SIZE: grid_cell_mm = value[9:0];
            REG_GRID_ROWS: grid_nrows = value[8:0];
            REG_GRID_COLS: grid_ncols = value[7:0];
            REG_MARGIN_EN: grid_margin = value[0];
            default: ;
        endcase
    endtask

    task automatic set_grid(int ox, int oy, int cs, int rows, int cols, int marg);
        write_reg(REG_ORIGIN_X, 32'(ox));
        write_reg(REG_ORIGIN_Y, 32'(oy));
        write_reg(REG_CELL_SIZE, 32'(cs));
        write_reg(REG_GRID_ROWS, 32'(rows));
        write_reg(REG_GRID_COLS, 32'(cols));
        write_reg(REG_MARGIN_EN, 32'(marg));
    endtask

    // Hold until every item has been sent and answered
    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_valid || expected_cells.size() != 0);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic queue_item(logic [1:0] mode, int x, int y, int ri);
        t_item it;
        it.mode = mode;
        it.x_mm = 16'(x);
        it.y_mm = 16'(y);
        it.read_index = 15'(ri);
        pending_items.push_back(it);
    endtask

    // Coordinate that lands near the grid, a little outside now and then
    function automatic int near_grid(int origin, int span);
        int k;
        k = int'($urandom_range(0, span + 3)) - 2;
        return origin + k * cell_mm() + int'($urandom_range(0, cell_mm() - 1));
    endfunction

    task automatic queue_random(int count);
        int pick, cells, rc, rr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 999);
            cells = rows_in_use() * cols_in_use();
            if (pick < 3) begin
                queue_item(MODE_CLEAR, 0, 0, 0);
            end else if (pick < 550) begin
                queue_item(MODE_POINT, near_grid(grid_org_x, cols_in_use()),
                           near_grid(grid_org_y, rows_in_use()), $urandom);
            end else if (pick < 650) begin
                queue_item(MODE_POINT, $urandom, $urandom, $urandom);
            end else if (pick < 970) begin
                rc = coord_to_cell(0, grid_org_x);
                rr = coord_to_cell(0, grid_org_y);
                if (cells > 0 && $urandom_range(0, 9) < 7)
                    queue_item(MODE_READ, $urandom, $urandom, $urandom_range(0, cells - 1));
                else if ($urandom_range(0, 1))
                    queue_item(MODE_READ, $urandom, $urandom, rr * cols_in_use() + rc + 1);
                else
                    queue_item(MODE_READ, $urandom, $urandom, $urandom);
            end else begin
                queue_item(MODE_NONE, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        int grid_set[8][6];
        grid_set = '{
            '{0, -7000, 100, 140, 70, 1},
            '{-500, -400, 100, 8, 8, 1},
            '{32767, -32768, 1, 256, 128, 0},
            '{-32768, 32767, 1000, 511, 255, 1},
            '{-300, -300, 0, 4, 5, 1},
            '{100, 100, 1023, 0, 10, 1},
            '{-1000, -2000, 250, 3, 0, 0},
            '{-64, -64, 16, 1, 1, 1}
        };
        for (int i = 0; i < NUM_CELLS; i++) occupancy[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset configuration
        queue_item(MODE_READ, 0, 0, 0);
        queue_item(MODE_POINT, 0, 0, 0);
        queue_item(MODE_POINT, 50, -6950, 0);
        queue_item(MODE_POINT, 6999, 6999, 0);
        queue_item(MODE_POINT, 7000, 0, 0);
        queue_item(MODE_POINT, -1, 0, 0);
        queue_item(MODE_POINT, -32768, -32768, 0);
        queue_item(MODE_POINT, 32767, 32767, 32767);
        for (int k = 0; k < 11; k++) queue_item(MODE_POINT, 120, 120, 0);
        queue_item(MODE_READ, 0, 0, 70 * 70 + 1);
        queue_item(MODE_READ, 0, 0, 70 * 70 + 2);
        queue_item(MODE_READ, 0, 0, 70 * 71 + 1);
        queue_item(MODE_READ, 0, 0, 32767);
        queue_item(MODE_NONE, -1, -1, 32767);
        queue_item(MODE_CLEAR, 0, 0, 0);
        queue_item(MODE_READ, 0, 0, 70 * 71 + 1);
        drain();

        // Random phases over several grid settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            set_grid(grid_set[ph][0], grid_set[ph][1], grid_set[ph][2],
                     grid_set[ph][3], grid_set[ph][4], grid_set[ph][5]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            queue_random(200);
            drain();
        end

        if (errors == 0 && expected_cells.size() == 0) begin
            $display("tb_point_to_occupancy_grid_unit: done, clean");
        end else begin
            $display("tb_point_to_occupancy_grid_unit: done, errors");
        end
        $finish;
    end
endmodule
